/* src/clnw_pkg.sv */
// Shared types and constants for the character LCD nibble writer.
// Used by clnw_decode, the top level and the testbench; depends on nothing else.
`timescale 1ns / 1ps

package clnw_pkg;

    // Operation codes of an input request.
    localparam logic [1:0] OP_COMMAND    = 2'd0;
    localparam logic [1:0] OP_CHARACTER  = 2'd1;
    localparam logic [1:0] OP_WRAP_START = 2'd2;
    localparam logic [1:0] OP_SET_CURSOR = 2'd3;

    // Status codes of a result.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_DROPPED  = 2'd2;

    // Register index of the backlight control.
    localparam logic REG_BACKLIGHT = 1'b0;

    // Expander byte bits and the address command.
    localparam logic [7:0] NIB_MASK = 8'hf0;
    localparam logic [7:0] ADDR_CMD = 8'h80;

    // Input request and result item.
    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] byte_value;
        logic [7:0] column;
        logic [7:0] row;
    } t_in;

    typedef struct packed {
        logic [7:0] expander_byte;
        logic       last;
        logic [1:0] status;
    } t_out;

    // How many results a decoded request produces.
    typedef enum logic [1:0] {
        KIND_FLAG = 2'd0,
        KIND_ONE  = 2'd1,
        KIND_TWO  = 2'd2
    } t_kind;

    // One decoded request: up to two LCD bytes to be split into nibbles.
    typedef struct packed {
        logic [7:0] byte0;
        logic       sel0;
        logic [7:0] byte1;
        logic       sel1;
        t_kind      kind;
        logic [1:0] status;
    } t_job;

    // Text session state.
    typedef struct packed {
        logic       wrap;
        logic       full;
        logic [4:0] column;
        logic [1:0] row;
    } t_state;

    // DDRAM start address of each display row.
    function automatic logic [7:0] row_start(input logic [1:0] r);
        logic [7:0] a;
        case (r)
            2'd0:    a = 8'h00;
            2'd1:    a = 8'h40;
            2'd2:    a = 8'h14;
            default: a = 8'h54;
        endcase
        return a;
    endfunction

endpackage

/* src/clnw_decode.sv */
// Request decoder: turns one request and the session state into a job and
// the next session state. Depends on clnw_pkg.
`timescale 1ns / 1ps

module clnw_decode #(
    parameter int LINE_LENGTH = 16,
    parameter int LINE_COUNT  = 2
) (
    input  clnw_pkg::t_in    i_req,
    input  clnw_pkg::t_state i_state,
    output clnw_pkg::t_job   o_job,
    output clnw_pkg::t_state o_next
);
    import clnw_pkg::*;

    // Reciprocal of the line length; exact quotient for any 8-bit column.
    localparam int RECIP = (65536 + LINE_LENGTH - 1) / LINE_LENGTH;

    logic [24:0] prod;
    logic [7:0]  quot;
    logic [12:0] qmul;
    logic [4:0]  rem;
    logic [8:0]  start_row;
    logic [1:0]  cursor_row;
    logic [2:0]  next_row;

    // Split the start column into a row offset and a column within the line.
    always_comb begin
        prod       = 25'(i_req.column) * 25'(RECIP);
        quot       = prod[23:16];
        qmul       = 13'(quot) * 13'(LINE_LENGTH);
        rem        = 5'(13'(i_req.column) - qmul);
        start_row  = 9'(i_req.row) + 9'(quot);
        cursor_row = (i_req.row >= 8'(LINE_COUNT)) ? 2'(LINE_COUNT - 1) : i_req.row[1:0];
        next_row   = 3'(i_state.row) + 3'd1;
    end

    // Per-operation job and state update.
    always_comb begin
        o_next       = i_state;
        o_job.byte0  = i_req.byte_value;
        o_job.sel0   = 1'b0;
        o_job.byte1  = i_req.byte_value;
        o_job.sel1   = 1'b1;
        o_job.kind   = KIND_ONE;
        o_job.status = ST_OK;
        case (i_req.operation)
            OP_COMMAND: begin
                o_next.wrap = 1'b0;
            end
            OP_SET_CURSOR: begin
                o_next.wrap = 1'b0;
                o_job.byte0 = ADDR_CMD | (i_req.column + row_start(cursor_row));
            end
            OP_WRAP_START: begin
                if (start_row >= 9'(LINE_COUNT)) begin
                    o_next.wrap  = 1'b0;
                    o_job.kind   = KIND_FLAG;
                    o_job.status = ST_OVERFLOW;
                end else begin
                    o_next.wrap   = 1'b1;
                    o_next.full   = 1'b0;
                    o_next.column = rem;
                    o_next.row    = start_row[1:0];
                    o_job.byte0   = ADDR_CMD | (8'(rem) + row_start(start_row[1:0]));
                end
            end
            default: begin
                // Character: plain write outside a session, tracked inside one.
                o_job.sel0 = 1'b1;
                if (i_state.wrap) begin
                    if (i_state.full) begin
                        o_job.kind   = KIND_FLAG;
                        o_job.status = ST_DROPPED;
                    end else if (i_state.column >= 5'(LINE_LENGTH)) begin
                        if (next_row >= 3'(LINE_COUNT)) begin
                            o_next.full  = 1'b1;
                            o_job.kind   = KIND_FLAG;
                            o_job.status = ST_DROPPED;
                        end else begin
                            // Line end: row-start address first, then the character.
                            o_next.row    = next_row[1:0];
                            o_next.column = 5'd1;
                            o_job.byte0   = ADDR_CMD | row_start(next_row[1:0]);
                            o_job.sel0    = 1'b0;
                            o_job.kind    = KIND_TWO;
                        end
                    end else begin
                        o_next.column = i_state.column + 5'd1;
                    end
                end
            end
        endcase
    end

endmodule

/* src/char_lcd_nibble_writer_with_wrap_top.sv */
// Top level of the character LCD nibble writer: APB register, session state,
// job register and nibble serializer. Depends on clnw_pkg and clnw_decode.
`timescale 1ns / 1ps

// Usage:
// Requests enter on i_req with i_valid/o_ready; each carries an operation
// (command, character, wrapped-text start, set cursor) and its operands.
// Results leave on o_result with o_valid/i_ready, one expander byte per
// cycle while i_ready is high. A command, character, set cursor or valid
// wrapped-text start gives four bytes, a line-end character in a session
// gives eight, and an overflow or dropped character gives one flag result
// with a nonzero status. The last result of a request has last set. The
// first result appears in the cycle after acceptance. The output side paces
// the block: the next request is taken in the same cycle that the final
// result of the current one is taken, so there is no gap between requests.
// If the receiver stalls, the current result holds and no request is taken.
// Reset clears the session and the job register and turns the backlight on.
// The backlight register sits at APB addresses 0 to 3; pready is always high.
module char_lcd_nibble_writer_with_wrap_top #(
    parameter int LINE_LENGTH = 16,
    parameter int LINE_COUNT  = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  clnw_pkg::t_in    i_req,
    output logic             o_valid,
    input  logic             i_ready,
    output clnw_pkg::t_out   o_result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import clnw_pkg::*;

    logic       r_backlight;
    t_state     r_state;
    t_state     n_state;
    t_job       r_job;
    t_job       n_job;
    logic       r_valid;
    logic [2:0] r_count;
    logic       in_take;
    logic       out_take;
    logic       is_last;
    logic [7:0] cur_byte;
    logic       cur_sel;
    logic [3:0] nibble;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BACKLIGHT) ? {31'd0, r_backlight} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_backlight <= 1'b1;
        end else if (psel && penable && pwrite && paddr[2] == REG_BACKLIGHT) begin
            r_backlight <= pwdata[0];
        end
    end

    // Decoder for the incoming request.
    clnw_decode #(
        .LINE_LENGTH(LINE_LENGTH),
        .LINE_COUNT (LINE_COUNT)
    ) u_decode (
        .i_req  (i_req),
        .i_state(r_state),
        .o_job  (n_job),
        .o_next (n_state)
    );

    // Handshakes: a new request is taken when the job register is empty or its last result is taken.
    always_comb begin
        case (r_job.kind)
            KIND_FLAG: is_last = 1'b1;
            KIND_ONE:  is_last = (r_count == 3'd3);
            default:   is_last = (r_count == 3'd7);
        endcase
    end

    assign out_take = r_valid && i_ready;
    assign o_ready  = !r_valid || (i_ready && is_last);
    assign in_take  = i_valid && o_ready;

    // Session state advances on each accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_take) begin
            r_state <= n_state;
        end
    end

    // Job register and nibble counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= 3'd0;
        end else if (out_take) begin
            if (is_last) begin
                r_valid <= in_take;
                r_count <= 3'd0;
            end else begin
                r_count <= r_count + 3'd1;
            end
        end else if (in_take) begin
            r_valid <= 1'b1;
            r_count <= 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job <= '0;
        end else if (in_take) begin
            r_job <= n_job;
        end
    end

    // Result: high nibble then low nibble, each with enable set then clear.
    always_comb begin
        cur_byte = r_count[2] ? r_job.byte1 : r_job.byte0;
        cur_sel  = r_count[2] ? r_job.sel1 : r_job.sel0;
        nibble   = r_count[1] ? cur_byte[3:0] : cur_byte[7:4];
        if (r_job.kind == KIND_FLAG) begin
            o_result.expander_byte = 8'd0;
        end else begin
            o_result.expander_byte = {nibble, r_backlight, !r_count[0], 1'b0, cur_sel};
        end
        o_result.last   = is_last;
        o_result.status = r_job.status;
    end

    assign o_valid = r_valid;

    // Assertions.
    a_take_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |-> (!r_valid || (i_ready && is_last)))
        else $error("request taken while a job is still being sent");

    a_flag_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_job.kind == KIND_FLAG) |-> (r_count == 3'd0))
        else $error("flag result counter moved");

    a_column_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.wrap |-> (r_state.column <= 5'(LINE_LENGTH)))
        else $error("session column beyond line length");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.wrap |-> (3'(r_state.row) < 3'(LINE_COUNT)))
        else $error("session row beyond last line");

endmodule

/* test/tb_clnw_checker.sv */
// Checker for the character LCD nibble writer: watches both channels and the
// APB port, predicts the expander bytes of each request and compares them.
// Depends on clnw_pkg for the payload types and the operation and status codes.
`timescale 1ns / 1ps

module tb_clnw_checker #(
    parameter int LINE_LENGTH = 16,
    parameter int LINE_COUNT  = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  logic           i_req_ready,
    input  clnw_pkg::t_in  i_req,
    input  logic           i_res_valid,
    input  logic           i_res_ready,
    input  clnw_pkg::t_out i_result,
    input  logic           i_psel,
    input  logic           i_penable,
    input  logic           i_pwrite,
    input  logic           i_pready,
    input  logic [2:0]     i_paddr,
    input  logic [31:0]    i_pwdata,
    output int             o_outstanding,
    output int             o_fail_count
);
    import clnw_pkg::*;

    // DDRAM start address of rows 0 to 3, row 0 in the low byte.
    localparam logic [31:0] ROW_BASES     = {8'h54, 8'h14, 8'h40, 8'h00};
    localparam logic [7:0]  ENABLE_BIT    = 8'h04;
    localparam logic [2:0]  BACKLIGHT_ADR = {REG_BACKLIGHT, 2'b00};

    // Mirror of the register and the text session.
    logic       backlight;
    logic       in_session;
    logic       lines_full;
    logic [4:0] cursor_col;
    logic [1:0] cursor_row;

    t_out expected_bytes[$];
    int   fail_count;

    function automatic logic [7:0] row_base(input logic [1:0] r);
        return ROW_BASES[r * 8 +: 8];
    endfunction

    function automatic void push_expected(input logic [7:0] value, input logic [1:0] status);
        t_out e;
        e.expander_byte = value;
        e.last          = 1'b0;
        e.status        = status;
        expected_bytes.push_back(e);
    endfunction

    // One LCD byte goes out as two nibbles, each strobed with enable high then low.
    function automatic void push_lcd_byte(input logic [7:0] value, input logic sel);
        logic [7:0] ctl;
        logic [7:0] hi;
        logic [7:0] lo;
        ctl = {4'b0000, backlight, 2'b00, sel};
        hi  = (value & NIB_MASK) | ctl;
        lo  = {value[3:0], 4'b0000} | ctl;
        push_expected(hi | ENABLE_BIT, ST_OK);
        push_expected(hi, ST_OK);
        push_expected(lo | ENABLE_BIT, ST_OK);
        push_expected(lo, ST_OK);
    endfunction

    // Work out the results of one accepted request and advance the session.
    function automatic void predict_results(input t_in req);
        int         line;
        int         next_row;
        logic [7:0] col_in_line;
        logic [7:0] clamped_row;
        int         idx;
        t_out       tail;
        case (req.operation)
            OP_COMMAND: begin
                in_session = 1'b0;
                push_lcd_byte(req.byte_value, 1'b0);
            end
            OP_SET_CURSOR: begin
                in_session  = 1'b0;
                clamped_row = (req.row >= LINE_COUNT) ? 8'(LINE_COUNT - 1) : req.row;
                push_lcd_byte(ADDR_CMD | 8'(req.column + row_base(clamped_row[1:0])), 1'b0);
            end
            OP_WRAP_START: begin
                line       = int'(req.row) + int'(req.column) / LINE_LENGTH;
                in_session = 1'b0;
                if (line >= LINE_COUNT) begin
                    push_expected(8'h00, ST_OVERFLOW);
                end else begin
                    col_in_line = 8'(int'(req.column) % LINE_LENGTH);
                    in_session  = 1'b1;
                    lines_full  = 1'b0;
                    cursor_col  = col_in_line[4:0];
                    cursor_row  = 2'(line);
                    push_lcd_byte(ADDR_CMD | 8'(col_in_line + row_base(2'(line))), 1'b0);
                end
            end
            default: begin
                if (!in_session) begin
                    push_lcd_byte(req.byte_value, 1'b1);
                end else if (lines_full) begin
                    push_expected(8'h00, ST_DROPPED);
                end else if (cursor_col >= LINE_LENGTH) begin
                    // Line end: move to the next row or mark the display full.
                    next_row = int'(cursor_row) + 1;
                    if (next_row >= LINE_COUNT) begin
                        lines_full = 1'b1;
                        push_expected(8'h00, ST_DROPPED);
                    end else begin
                        cursor_row = 2'(next_row);
                        push_lcd_byte(ADDR_CMD | row_base(2'(next_row)), 1'b0);
                        push_lcd_byte(req.byte_value, 1'b1);
                        cursor_col = 5'd1;
                    end
                end else begin
                    push_lcd_byte(req.byte_value, 1'b1);
                    cursor_col = cursor_col + 5'd1;
                end
            end
        endcase
        idx       = expected_bytes.size() - 1;
        tail      = expected_bytes[idx];
        tail.last = 1'b1;
        expected_bytes[idx] = tail;
    endfunction

    function automatic void report_mismatch(input string what, input t_out want, input t_out got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s: expected byte %02h last %0b status %0d, %s",
                     $time, what, want.expander_byte, want.last, want.status,
                     $sformatf("got byte %02h last %0b status %0d",
                               got.expander_byte, got.last, got.status));
    endfunction

    // Register writes, result comparison and request prediction, in that order.
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            backlight  = 1'b1;
            in_session = 1'b0;
            lines_full = 1'b0;
            cursor_col = '0;
            cursor_row = '0;
            fail_count = 0;
            expected_bytes.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == BACKLIGHT_ADR)
                backlight = i_pwdata[0];
            if (i_res_valid && i_res_ready) begin
                if (expected_bytes.size() == 0) begin
                    want = '0;
                    report_mismatch("unexpected result", want, i_result);
                end else begin
                    want = expected_bytes.pop_front();
                    // The byte of a flag result carries no meaning.
                    if (want.status != i_result.status || want.last != i_result.last ||
                        (want.status == ST_OK && want.expander_byte != i_result.expander_byte))
                        report_mismatch("result mismatch", want, i_result);
                end
            end
            if (i_req_valid && i_req_ready)
                predict_results(i_req);
        end
        o_outstanding <= expected_bytes.size();
        o_fail_count  <= fail_count;
    end

endmodule

/* test/tb_char_lcd_nibble_writer_with_wrap_top.sv */
// Testbench top for the character LCD nibble writer: clock, reset, requests,
// result back-pressure and backlight writes. Depends on clnw_pkg, the block and
// tb_clnw_checker, which predicts and compares the results.
`timescale 1ns / 1ps

module tb_char_lcd_nibble_writer_with_wrap_top;
    import clnw_pkg::*;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    t_in         req       = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    t_out        result;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        allow_idle = 1'b1;
    int          outstanding;
    int          fail_count;

    // 4 ns clock.
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    char_lcd_nibble_writer_with_wrap_top u_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_valid  (req_valid),
        .o_ready  (req_ready),
        .i_req    (req),
        .o_valid  (res_valid),
        .i_ready  (res_ready),
        .o_result (result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    tb_clnw_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req_valid   (req_valid),
        .i_req_ready   (req_ready),
        .i_req         (req),
        .i_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .i_result      (result),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_outstanding (outstanding),
        .o_fail_count  (fail_count)
    );

    // Result back-pressure: stall on about 31 percent of cycles when allowed.
    always @(posedge clk) begin
        if (!rst_n)
            res_ready <= 1'b0;
        else
            res_ready <= !(allow_idle && $urandom_range(99) < 31);
    end

    function automatic t_in make_req(input logic [1:0] op, input logic [7:0] val,
                                     input logic [7:0] col, input logic [7:0] row);
        t_in r;
        r.operation  = op;
        r.byte_value = val;
        r.column     = col;
        r.row        = row;
        return r;
    endfunction

    // Offer one request, with random gaps before it, and wait until it is taken.
    task automatic send_request(input t_in r);
        while (allow_idle && $urandom_range(99) < 31) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (!req_ready);
    endtask

    // Wait until every predicted result has been taken.
    task automatic wait_drained();
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_backlight(input logic value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_BACKLIGHT, 2'b00};
        pwdata  <= {31'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Run limit.
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int         sent;
        int         run_len;
        logic [7:0] start_row;
        logic [7:0] start_col;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_backlight(1'b1);

        // Directed part: field extremes, every operation and the session corners.
        send_request(make_req(OP_COMMAND, 8'h00, 8'h00, 8'h00));
        send_request(make_req(OP_COMMAND, 8'hff, 8'hff, 8'hff));
        send_request(make_req(OP_COMMAND, 8'ha5, 8'h00, 8'h00));
        send_request(make_req(OP_CHARACTER, 8'hff, 8'h00, 8'h00));
        send_request(make_req(OP_CHARACTER, 8'h00, 8'hff, 8'hff));
        send_request(make_req(OP_SET_CURSOR, 8'h00, 8'h00, 8'h00));
        send_request(make_req(OP_SET_CURSOR, 8'h00, 8'hff, 8'hff));
        send_request(make_req(OP_SET_CURSOR, 8'h5a, 8'h07, 8'h01));
        // Start positions past the last line.
        send_request(make_req(OP_WRAP_START, 8'h00, 8'h00, 8'h02));
        send_request(make_req(OP_WRAP_START, 8'h00, 8'hff, 8'h00));
        send_request(make_req(OP_WRAP_START, 8'h00, 8'hff, 8'hff));
        send_request(make_req(OP_CHARACTER, 8'h41, 8'h00, 8'h00));
        // Line end on the first row moves to the second row.
        send_request(make_req(OP_WRAP_START, 8'h00, 8'd14, 8'h00));
        send_request(make_req(OP_CHARACTER, 8'h41, 8'h00, 8'h00));
        send_request(make_req(OP_CHARACTER, 8'h42, 8'h00, 8'h00));
        send_request(make_req(OP_CHARACTER, 8'h43, 8'h00, 8'h00));
        // Column overflow at the start wraps; the last line fills and drops.
        send_request(make_req(OP_WRAP_START, 8'h00, 8'd31, 8'h00));
        send_request(make_req(OP_CHARACTER, 8'h44, 8'h00, 8'h00));
        send_request(make_req(OP_CHARACTER, 8'h45, 8'h00, 8'h00));
        send_request(make_req(OP_CHARACTER, 8'h46, 8'h00, 8'h00));
        send_request(make_req(OP_WRAP_START, 8'h00, 8'd16, 8'h00));
        send_request(make_req(OP_CHARACTER, 8'h47, 8'h00, 8'h00));
        // A new start replaces the session; set cursor ends it.
        send_request(make_req(OP_WRAP_START, 8'h00, 8'd3, 8'h00));
        send_request(make_req(OP_WRAP_START, 8'h00, 8'd5, 8'h01));
        send_request(make_req(OP_SET_CURSOR, 8'h00, 8'd2, 8'h00));
        send_request(make_req(OP_CHARACTER, 8'h48, 8'h00, 8'h00));
        req_valid <= 1'b0;
        wait_drained();

        // Random part in four phases with alternating backlight; phase 2 never idles.
        for (int phase = 0; phase < 4; phase++) begin
            write_backlight(phase[0]);
            allow_idle <= (phase != 2);
            sent = 0;
            while (sent < 125) begin
                if ($urandom_range(99) < 75) begin
                    // Well-formed session: valid start and a run of characters with an occasional random request.
                    start_row = 8'($urandom_range(1));
                    start_col = (start_row == 0) ? 8'($urandom_range(31)) : 8'($urandom_range(15));
                    send_request(make_req(OP_WRAP_START, 8'($urandom), start_col, start_row));
                    run_len = $urandom_range(40, 1);
                    for (int k = 0; k < run_len; k++) begin
                        if ($urandom_range(99) < 4)
                            send_request(t_in'(26'($urandom)));
                        else
                            send_request(make_req(OP_CHARACTER, 8'($urandom), 8'($urandom),
                                                  8'($urandom)));
                    end
                    sent += run_len + 1;
                end else begin
                    send_request(t_in'(26'($urandom)));
                    sent++;
                end
            end
            req_valid <= 1'b0;
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
